/* hw/rtl/mrsl_pkg.sv */
// Shared types, codes and constants of the motor ramp with soft limits.
// Used by mrsl_step, the top level and the checker; depends on nothing.
package mrsl_pkg;

    localparam int SPEED_W     = 17;
    localparam int TIME_W      = 32;
    localparam int ENC_W       = 32;
    localparam int POWER_W     = 8;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 3;

    localparam int MILLI        = 1000;
    localparam int LIMIT_MARGIN = 10;
    localparam int POWER_CAP    = 100;

    // Reciprocal of 1000 in units of 2^-26; floor is exact for x below 493447
    localparam int          RECIP_SHIFT = 26;
    localparam logic [16:0] RECIP_1000  = 17'd67109;

    typedef enum logic [1:0] {
        FUNC_FWD  = 2'd0,
        FUNC_BCK  = 2'd1,
        FUNC_STOP = 2'd2,
        FUNC_TICK = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_SET_POWER = 2'd1,
        ACT_COAST     = 2'd2,
        ACT_BRAKE     = 2'd3
    } action_t;

    // Motor mode, one-hot internally
    typedef enum logic [2:0] {
        MODE_STOP = 3'b001,
        MODE_FWD  = 3'b010,
        MODE_BCK  = 3'b100
    } mode_t;

    // Mode codes as shown on the result channel
    localparam logic [1:0] MODE_CODE_STOP = 2'd0;
    localparam logic [1:0] MODE_CODE_FWD  = 2'd1;
    localparam logic [1:0] MODE_CODE_BCK  = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIR_SIGN      = 3'd0,
        CFG_UPPER_LIMIT   = 3'd1,
        CFG_HOME_OFFSET   = 3'd2,
        CFG_RAMP_DELAY_MS = 3'd3,
        CFG_ACCEL_RATE    = 3'd4,
        CFG_MIN_SPEED     = 3'd5,
        CFG_MAX_SPEED     = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [1:0]  dir_sign;
        logic [23:0]        upper_limit;
        logic signed [23:0] home_offset;
        logic [15:0]        ramp_delay_ms;
        logic [13:0]        accel_rate;
        logic [6:0]         min_speed;
        logic [6:0]         max_speed;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        dir_sign:      2'sd1,
        upper_limit:   24'd1000,
        home_offset:   24'sd0,
        ramp_delay_ms: 16'd1000,
        accel_rate:    14'd10,
        min_speed:     7'd10,
        max_speed:     7'd100
    };

    typedef struct packed {
        func_t                    func;
        logic [TIME_W-1:0]        now_ms;
        logic signed [ENC_W-1:0]  encoder_count;
        logic                     soft_lim_en;
        logic                     brake_stop;
    } item_t;

    typedef struct packed {
        mode_t               mode;
        logic [TIME_W-1:0]   start_time;
        logic [SPEED_W-1:0]  ramp_speed;
    } state_t;

    localparam state_t STATE_RESET = '{
        mode:       MODE_STOP,
        start_time: '0,
        ramp_speed: '0
    };

    // Action plus what the power stage needs: |dir| is two, power negated
    typedef struct packed {
        action_t action;
        logic    pwr_dbl;
        logic    pwr_neg;
    } result_t;

    function automatic logic [1:0] mode_code(input mode_t mode);
        logic [1:0] code;
        unique case (mode)
            MODE_FWD: code = MODE_CODE_FWD;
            MODE_BCK: code = MODE_CODE_BCK;
            default:  code = MODE_CODE_STOP;
        endcase
        return code;
    endfunction

    // floor(x / 1000) clamped to 100, by multiplying with the reciprocal
    function automatic logic [6:0] power_mag(input logic [SPEED_W:0] x);
        logic [34:0] prod;
        logic [6:0]  quo;
        prod = 35'(x) * 35'(RECIP_1000);
        if (x >= (SPEED_W+1)'(POWER_CAP * MILLI)) begin
            quo = 7'(POWER_CAP);
        end else begin
            quo = prod[RECIP_SHIFT +: 7];
        end
        return quo;
    endfunction

endpackage

/* hw/rtl/mrsl_step.sv */
// Next state and action of the ramp for one command beat.
// Combinational; depends on mrsl_pkg.
module mrsl_step
    import mrsl_pkg::*;
(
    input  cfg_t    cfg,
    input  item_t   item,
    input  state_t  cur_state,
    output state_t  state_next,
    output result_t result
);

    logic                     is_run_cmd;
    mode_t                    want_mode;
    logic                     new_run;
    logic                     do_tick;
    mode_t                    eff_mode;

    logic [SPEED_W-1:0]       base_speed;
    logic [SPEED_W-1:0]       cap_speed;
    logic [SPEED_W-1:0]       start_speed;
    logic [TIME_W-1:0]        elapsed;
    logic                     ramping;
    logic [TIME_W-1:0]        ramp_diff;
    logic [45:0]              ramp_prod;
    logic [46:0]              ramp_sum;
    logic [46:0]              tick_raw;
    logic [SPEED_W-1:0]       tick_speed;
    logic [SPEED_W-1:0]       run_speed;

    logic signed [ENC_W+1:0]  dir_enc;
    logic signed [ENC_W+2:0]  pos;
    logic signed [ENC_W+2:0]  lim_hi;
    logic                     limit_hit;

    logic                     dir_dbl;
    logic                     dir_zero;
    logic                     zero_power;

    assign is_run_cmd = (item.func == FUNC_FWD) || (item.func == FUNC_BCK);
    assign want_mode  = (item.func == FUNC_FWD) ? MODE_FWD : MODE_BCK;
    assign new_run    = is_run_cmd && (cur_state.mode != want_mode);
    assign do_tick    = (is_run_cmd && (cur_state.mode == want_mode))
                     || ((item.func == FUNC_TICK) && (cur_state.mode != MODE_STOP));
    assign eff_mode   = new_run ? want_mode : cur_state.mode;

    // Speed in thousandths of a percent
    assign base_speed  = SPEED_W'(cfg.min_speed) * SPEED_W'(MILLI);
    assign cap_speed   = SPEED_W'(cfg.max_speed) * SPEED_W'(MILLI);
    assign start_speed = (base_speed < cap_speed) ? base_speed : cap_speed;

    assign elapsed    = item.now_ms - cur_state.start_time;
    assign ramping    = elapsed > TIME_W'(cfg.ramp_delay_ms);
    assign ramp_diff  = elapsed - TIME_W'(cfg.ramp_delay_ms);
    assign ramp_prod  = 46'(ramp_diff) * 46'(cfg.accel_rate);
    assign ramp_sum   = 47'(ramp_prod) + 47'(base_speed);
    assign tick_raw   = ramping ? ramp_sum : 47'(base_speed);
    assign tick_speed = (tick_raw < 47'(cap_speed)) ? tick_raw[SPEED_W-1:0] : cap_speed;
    assign run_speed  = new_run ? start_speed : tick_speed;

    // Position = home offset + direction * count
    always_comb begin
        unique case (cfg.dir_sign)
            2'sb01:  dir_enc = (ENC_W+2)'(item.encoder_count);
            2'sb11:  dir_enc = -(ENC_W+2)'(item.encoder_count);
            2'sb10:  dir_enc = -((ENC_W+2)'(item.encoder_count) <<< 1);
            default: dir_enc = '0;
        endcase
    end

    assign pos    = (ENC_W+3)'(dir_enc) + (ENC_W+3)'(cfg.home_offset);
    assign lim_hi = $signed((ENC_W+3)'({1'b0, cfg.upper_limit}))
                  - $signed((ENC_W+3)'(LIMIT_MARGIN));

    assign limit_hit = item.soft_lim_en
        && (((eff_mode == MODE_FWD) && (pos > lim_hi))
         || ((eff_mode == MODE_BCK) && (pos < $signed((ENC_W+3)'(LIMIT_MARGIN)))));

    // Power is zero when |dir| * speed stays below one percent
    assign dir_dbl    = (cfg.dir_sign == 2'sb10);
    assign dir_zero   = (cfg.dir_sign == 2'sb00);
    assign zero_power = dir_zero
        || (dir_dbl ? (run_speed < SPEED_W'(MILLI / 2)) : (run_speed < SPEED_W'(MILLI)));

    always_comb begin
        state_next     = cur_state;
        result.action  = ACT_NONE;
        result.pwr_dbl = 1'b0;
        result.pwr_neg = 1'b0;
        priority if (new_run || do_tick) begin
            state_next.mode = eff_mode;
            if (new_run) begin
                state_next.start_time = item.now_ms;
            end
            if (limit_hit) begin
                state_next.mode       = MODE_STOP;
                state_next.ramp_speed = '0;
                result.action         = ACT_BRAKE;
            end else begin
                state_next.ramp_speed = run_speed;
                result.action         = zero_power ? ACT_COAST : ACT_SET_POWER;
                result.pwr_dbl        = dir_dbl;
                result.pwr_neg        = cfg.dir_sign[1] ^ (eff_mode == MODE_BCK);
            end
        end else if ((item.func == FUNC_STOP) && (cur_state.mode != MODE_STOP)) begin
            state_next.mode       = MODE_STOP;
            state_next.ramp_speed = '0;
            result.action         = item.brake_stop ? ACT_BRAKE : ACT_COAST;
        end else begin
            result.action = ACT_NONE;
        end
    end

endmodule

/* hw/rtl/motor_ramp_with_soft_limits_unit.sv */
// Motor linear acceleration ramp with soft position limits, top level.
// Depends on mrsl_pkg and mrsl_step.
//
// Usage:
//   Command beats (forward, backward, stop, update tick with time, encoder
//   count and flags) enter on the s_ channel; one result beat per command
//   leaves on the m_ channel (power, action, mode after the command, ramp
//   speed in thousandths of a percent).
//   Path: an accepted command is held in the command register, then its
//   result in the result register, which drives the m_ channel.
//   Throughput: one command per cycle unless the result channel stalls.
//   The command register feeds one pass of logic (a 32x14 multiplier, a
//   limit compare and a cap compare) into the result register; ramp state
//   is written at the same edge, so the next command sees it at once.
//   Stall: while m_ready is low the result beat holds; one more command may
//   wait in the command register, then s_ready drops.
//   Reset (aresetn low at a clock edge): both channels empty, motor stopped,
//   start time and ramp speed zero, configuration registers back to their defaults.
//   Configuration writes (cfg_we, cfg_idx, cfg_wdata) take effect at the edge
//   and belong to idle periods only; indexes beyond the list are dropped.
module motor_ramp_with_soft_limits_unit
    import mrsl_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_idx,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_func,
    input  logic [TIME_W-1:0]          s_now_ms,
    input  logic signed [ENC_W-1:0]    s_encoder_count,
    input  logic                       s_soft_lim_en,
    input  logic                       s_brake_stop,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [POWER_W-1:0]  m_drive_power,
    output logic [1:0]                 m_drive_action,
    output logic [1:0]                 m_mode_out,
    output logic [SPEED_W-1:0]         m_speed_milli
);

    cfg_t    cfg_reg;
    logic    in_vld_reg,  in_vld_next;
    item_t   item_reg;
    state_t  state_reg,   state_next;
    logic    out_vld_reg, out_vld_next;
    result_t res_reg,     res_next;

    logic             s_fire;
    logic             advance;
    logic [SPEED_W:0] pwr_scaled;
    logic [6:0]       pwr_mag;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_idx))
                CFG_DIR_SIGN:      cfg_reg.dir_sign      <= cfg_wdata[1:0];
                CFG_UPPER_LIMIT:   cfg_reg.upper_limit   <= cfg_wdata[23:0];
                CFG_HOME_OFFSET:   cfg_reg.home_offset   <= cfg_wdata[23:0];
                CFG_RAMP_DELAY_MS: cfg_reg.ramp_delay_ms <= cfg_wdata[15:0];
                CFG_ACCEL_RATE:    cfg_reg.accel_rate    <= cfg_wdata[13:0];
                CFG_MIN_SPEED:     cfg_reg.min_speed     <= cfg_wdata[6:0];
                CFG_MAX_SPEED:     cfg_reg.max_speed     <= cfg_wdata[6:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Advance the command into the result register when that one is free
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_fire) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    mrsl_step u_step (
        .cfg        (cfg_reg),
        .item       (item_reg),
        .cur_state  (state_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= STATE_RESET;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Command and result payload: hold unless a beat moves
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.func          <= func_t'(s_func);
            item_reg.now_ms        <= s_now_ms;
            item_reg.encoder_count <= s_encoder_count;
            item_reg.soft_lim_en   <= s_soft_lim_en;
            item_reg.brake_stop    <= s_brake_stop;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    // Mode and speed of the result are the ramp state written with it
    assign pwr_scaled = res_reg.pwr_dbl ? {state_reg.ramp_speed, 1'b0}
                                        : {1'b0, state_reg.ramp_speed};
    assign pwr_mag    = power_mag(pwr_scaled);

    always_comb begin
        m_drive_power = '0;
        if (res_reg.action == ACT_SET_POWER) begin
            m_drive_power = res_reg.pwr_neg ? -$signed(POWER_W'(pwr_mag))
                                            :  $signed(POWER_W'(pwr_mag));
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_drive_action = res_reg.action;
    assign m_mode_out     = mode_code(state_reg.mode);
    assign m_speed_milli  = state_reg.ramp_speed;

endmodule

/* hw/rtl/mrsl_checker.sv */
// Port-level checks of the motor ramp top level, attached by bind.
// Depends on mrsl_pkg and motor_ramp_with_soft_limits_unit.
module mrsl_checker
    import mrsl_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [POWER_W-1:0]  m_drive_power,
    input logic [1:0]                 m_drive_action,
    input logic [1:0]                 m_mode_out,
    input logic [SPEED_W-1:0]         m_speed_milli
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_power)
            && $stable(m_drive_action) && $stable(m_mode_out) && $stable(m_speed_milli))
        else $error("result beat changed while stalled");

    // Power only accompanies a set-power action
    a_power_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_drive_action != ACT_SET_POWER) |-> m_drive_power == '0)
        else $error("power without set-power action");

    // A stopped motor keeps no ramp speed
    a_stop_speed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_mode_out == MODE_CODE_STOP) |-> m_speed_milli == '0)
        else $error("speed left while stopped");

    // Brake always ends a run; set power never comes from a stopped motor
    a_brake_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_drive_action == ACT_BRAKE) |-> m_mode_out == MODE_CODE_STOP)
        else $error("brake with motor still running");

    a_set_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_drive_action == ACT_SET_POWER) |-> m_mode_out != MODE_CODE_STOP)
        else $error("set power while stopped");

endmodule

bind motor_ramp_with_soft_limits_unit mrsl_checker u_mrsl_checker (.*);
